// ===== hdl/ihc_pkg.sv =====
// shared types and constants of the ipv4 header checker
`timescale 1ns / 1ps

package ihc_pkg;

    localparam int HDR_MIN_BYTES = 20;
    localparam logic [3:0] VERSION_IPV4 = 4'd4;
    localparam logic [3:0] VERSION_IPV6 = 4'd6;
    localparam logic [15:0] FLAG_DF = 16'h4000;
    localparam logic [15:0] SUM_GOOD = 16'hFFFF;

    localparam logic [2:0] ST_DELIVER   = 3'd0;
    localparam logic [2:0] ST_RUNT      = 3'd1;
    localparam logic [2:0] ST_IPV6_FWD  = 3'd2;
    localparam logic [2:0] ST_BAD_VER   = 3'd3;
    localparam logic [2:0] ST_OVERLEN   = 3'd4;
    localparam logic [2:0] ST_BOGUS_LEN = 3'd5;
    localparam logic [2:0] ST_CSUM_ERR  = 3'd6;
    localparam logic [2:0] ST_FRAGMENT  = 3'd7;

    localparam logic REG_CSUM_ENABLE = 1'b0;
    localparam logic REG_IPV6_PRESENT = 1'b1;

    localparam int OUT_BITS = 97;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef struct packed {
        logic [3:0]  version;
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [15:0] frag_field;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sum;
        logic [7:0]  high_byte;
    } hdr_t;

    typedef struct packed {
        logic csum_enable;
        logic ipv6_present;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [5:0]  header_len;
        logic [15:0] payload_len;
    } verdict_t;

endpackage

// ===== hdl/ihc_apb_regs.sv =====
// configuration registers behind the apb port
`timescale 1ns / 1ps

module ihc_apb_regs
    import ihc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.csum_enable <= 1'b1;
            cfg_reg.ipv6_present <= 1'b1;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_CSUM_ENABLE:  cfg_reg.csum_enable <= pwdata[0];
                REG_IPV6_PRESENT: cfg_reg.ipv6_present <= pwdata[0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CSUM_ENABLE:  prdata = {31'd0, cfg_reg.csum_enable};
            REG_IPV6_PRESENT: prdata = {31'd0, cfg_reg.ipv6_present};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/ihc_parser.sv =====
// header field capture, byte count and running ones-complement sum
`timescale 1ns / 1ps

module ihc_parser
    import ihc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 65535,
    parameter int CNT_W = $clog2(MAX_FRAME_BYTES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic             last,
    input  logic [7:0]       data_byte,
    output hdr_t             hdr_next,
    output logic [CNT_W-1:0] count_next
);

    hdr_t             hdr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [15:0]      idx;
    logic [16:0]      wide_sum;
    logic             room;

    assign idx = 16'(count_reg);
    assign room = count_reg < CNT_W'(MAX_FRAME_BYTES);
    assign wide_sum = {1'b0, hdr_reg.sum} + {1'b0, hdr_reg.high_byte, data_byte};

    always_comb
    begin
        hdr_next = hdr_reg;
        count_next = count_reg;
        if (room)
        begin
            case (idx) inside
                16'd0:
                begin
                    hdr_next.version = data_byte[7:4];
                    hdr_next.header_words = data_byte[3:0];
                end
                16'd2, 16'd3:   hdr_next.total_length = {hdr_reg.total_length[7:0], data_byte};
                16'd6, 16'd7:   hdr_next.frag_field = {hdr_reg.frag_field[7:0], data_byte};
                16'd9:          hdr_next.protocol = data_byte;
                [16'd12:16'd15]: hdr_next.src_addr = {hdr_reg.src_addr[23:0], data_byte};
                [16'd16:16'd19]: hdr_next.dst_addr = {hdr_reg.dst_addr[23:0], data_byte};
                default:        hdr_next = hdr_reg;
            endcase
            // the first byte already counts against its own header length
            if (idx < {10'd0, hdr_next.header_words, 2'b00})
            begin
                if (!idx[0])
                begin
                    hdr_next.high_byte = data_byte;
                end
                else
                begin
                    hdr_next.sum = wide_sum[15:0] + {15'd0, wide_sum[16]};
                end
            end
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= '0;
            count_reg <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                hdr_reg <= '0;
                count_reg <= '0;
            end
            else
            begin
                hdr_reg <= hdr_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

// ===== hdl/ihc_verdict.sv =====
// verdict logic and result register
`timescale 1ns / 1ps

module ihc_verdict
    import ihc_pkg::*;
#(
    parameter int CNT_W = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             drain,
    input  cfg_t             cfg,
    input  hdr_t             hdr,
    input  logic [CNT_W-1:0] count,
    output logic             valid,
    output verdict_t         result
);

    verdict_t verdict_next;
    verdict_t result_reg;
    logic     valid_reg;
    logic [15:0] captured;
    logic [15:0] hlen16;
    logic [15:0] ip_len;
    logic [5:0]  hlen;
    logic        is_frag;

    assign captured = 16'(count);
    assign hlen = {hdr.header_words, 2'b00};
    assign hlen16 = {10'd0, hlen};
    assign is_frag = (hdr.frag_field != 16'd0) && (hdr.frag_field != FLAG_DF);
    assign ip_len = (!cfg.csum_enable && hdr.total_length <= hlen16) ?
                    captured : hdr.total_length;

    always_comb
    begin
        verdict_next = '0;
        if (captured < 16'(HDR_MIN_BYTES))
        begin
            verdict_next.status = ST_RUNT;
        end
        else if (hdr.version != VERSION_IPV4)
        begin
            verdict_next.status = (hdr.version == VERSION_IPV6 && cfg.ipv6_present) ?
                                  ST_IPV6_FWD : ST_BAD_VER;
        end
        else if (hdr.total_length > captured)
        begin
            verdict_next.status = ST_OVERLEN;
        end
        else if (cfg.csum_enable && hdr.total_length <= hlen16)
        begin
            verdict_next.status = ST_BOGUS_LEN;
        end
        else if (cfg.csum_enable && hdr.sum != SUM_GOOD)
        begin
            verdict_next.status = ST_CSUM_ERR;
        end
        else if (is_frag)
        begin
            verdict_next.status = ST_FRAGMENT;
        end
        else
        begin
            verdict_next.status = ST_DELIVER;
            verdict_next.protocol = hdr.protocol;
            verdict_next.src_addr = hdr.src_addr;
            verdict_next.dst_addr = hdr.dst_addr;
            verdict_next.header_len = hlen;
            verdict_next.payload_len = (ip_len > hlen16) ? (ip_len - hlen16) : 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (drain)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (load)
        begin
            result_reg <= verdict_next;
        end
    end

    assign valid = valid_reg;
    assign result = result_reg;

endmodule

// ===== hdl/ipv4_header_checker_top.sv =====
// top level of the ipv4 header checker
`timescale 1ns / 1ps

// Takes a captured packet one byte per transfer on the slave stream, header first, with
// s_tlast on the final byte, and gives one verdict transfer per packet on the master stream.
// Header fields, the byte count and the checksum are updated as each byte is taken, and
// the last byte's verdict is decided in the same cycle into the result register, so bytes
// flow at one per cycle when not stalled and the next packet may follow at once. The slave
// side only stalls while a verdict waits in the result register and m_tready is low. Bytes
// beyond MAX_FRAME_BYTES are ignored apart from s_tlast. Configuration is taken over the apb
// port: register 0 at address 0 enables the bogus length and checksum checks, register 1 at address 4
// marks an ipv6 handler as present; both reset to 1.

module ipv4_header_checker_top
    import ihc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 65535
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // data_byte
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_BYTES*8-1:0]  m_tdata,   // status, protocol, src_addr, dst_addr,
                                               // header_len, payload_len
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    cfg_t             cfg;
    hdr_t             hdr_next;
    logic [CNT_W-1:0] count_next;
    verdict_t         result;
    logic             take;
    logic             drain;

    assign drain = m_tvalid && m_tready;
    assign s_tready = !m_tvalid || m_tready;
    assign take = s_tvalid && s_tready;

    ihc_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ihc_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CNT_W           (CNT_W)
    ) u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .last       (s_tlast),
        .data_byte  (s_tdata),
        .hdr_next   (hdr_next),
        .count_next (count_next)
    );

    ihc_verdict #(
        .CNT_W (CNT_W)
    ) u_verdict
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (take && s_tlast),
        .drain  (drain),
        .cfg    (cfg),
        .hdr    (hdr_next),
        .count  (count_next),
        .valid  (m_tvalid),
        .result (result)
    );

    assign m_tdata = {(OUT_BYTES * 8 - OUT_BITS)'(0), result.payload_len, result.header_len,
                      result.dst_addr, result.src_addr, result.protocol, result.status};

endmodule

// ===== bench/tb.sv =====
// testbench of the ipv4 header checker: directed and random packets checked against a shadow
`timescale 1ns / 1ps

module tb;
    import ihc_pkg::*;

    localparam int FRAME_CAP = 200;
    localparam int LIMIT = 1500000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_BYTES = 450;

    typedef struct packed {
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] tot_len;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] cap_len;
        logic        good_sum;
    } pkt_desc_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'd0;     // data_byte
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_BYTES*8-1:0] m_tdata;            // status, protocol, src_addr, dst_addr,
                                                // header_len, payload_len
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = 3'd0;
    logic [31:0]            pwdata = 32'd0;
    logic [31:0]            prdata;
    logic                   pready;

    // shadow of the checker: settings and per-packet header state
    logic        cfg_check = 1'b1;
    logic        cfg_v6 = 1'b1;
    logic [15:0] sh_count;
    logic [3:0]  sh_ver;
    logic [3:0]  sh_ihl;
    logic [15:0] sh_tot;
    logic [15:0] sh_frag;
    logic [7:0]  sh_proto;
    logic [31:0] sh_src;
    logic [31:0] sh_dst;
    logic [16:0] sh_sum;
    logic [7:0]  sh_hi;

    verdict_t    verdicts_due[$];
    logic [7:0]  pkt_bytes[$];
    int          fails = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;

    ipv4_header_checker_top #(.MAX_FRAME_BYTES(FRAME_CAP)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic void clear_shadow();
        sh_count = '0;
        sh_ver = '0;
        sh_ihl = '0;
        sh_tot = '0;
        sh_frag = '0;
        sh_proto = '0;
        sh_src = '0;
        sh_dst = '0;
        sh_sum = '0;
        sh_hi = '0;
    endfunction

    // update the shadow with one accepted byte; the last byte yields the verdict
    function automatic void ingest_byte(logic [7:0] b, logic last);
        int          idx;
        int          hlen;
        int          ip_len;
        logic [16:0] s;
        verdict_t    v;
        if (sh_count < FRAME_CAP)
        begin
            idx = sh_count;
            if (idx == 0)
            begin
                sh_ver = b[7:4];
                sh_ihl = b[3:0];
            end
            else if (idx == 2 || idx == 3)
                sh_tot = {sh_tot[7:0], b};
            else if (idx == 6 || idx == 7)
                sh_frag = {sh_frag[7:0], b};
            else if (idx == 9)
                sh_proto = b;
            else if (idx >= 12 && idx <= 15)
                sh_src = {sh_src[23:0], b};
            else if (idx >= 16 && idx <= 19)
                sh_dst = {sh_dst[23:0], b};
            if (idx < int'(sh_ihl) * 4)
            begin
                if (idx % 2 == 0)
                    sh_hi = b;
                else
                begin
                    s = sh_sum + {1'b0, sh_hi, b};
                    s = {1'b0, s[15:0]} + s[16];
                    sh_sum = s;
                end
            end
            sh_count = sh_count + 16'd1;
        end
        if (!last)
            return;
        hlen = int'(sh_ihl) * 4;
        ip_len = sh_tot;
        v = '0;
        if (sh_count < HDR_MIN_BYTES)
            v.status = ST_RUNT;
        else if (sh_ver != VERSION_IPV4)
            v.status = (sh_ver == VERSION_IPV6 && cfg_v6) ? ST_IPV6_FWD : ST_BAD_VER;
        else if (sh_tot > sh_count)
            v.status = ST_OVERLEN;
        else if (cfg_check && int'(sh_tot) <= hlen)
            v.status = ST_BOGUS_LEN;
        else if (cfg_check && sh_sum[15:0] != SUM_GOOD)
            v.status = ST_CSUM_ERR;
        else
        begin
            if (!cfg_check && ip_len <= hlen)
                ip_len = sh_count;
            if (sh_frag != 16'd0 && sh_frag != FLAG_DF)
                v.status = ST_FRAGMENT;
            else
            begin
                v.status = ST_DELIVER;
                v.protocol = sh_proto;
                v.src_addr = sh_src;
                v.dst_addr = sh_dst;
                v.header_len = 6'(hlen);
                v.payload_len = 16'((ip_len > hlen) ? ip_len - hlen : 0);
            end
        end
        verdicts_due.push_back(v);
        clear_shadow();
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("verdict with none pending: %h", m_tdata);
                fails++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                check_field("status", want.status, m_tdata[2:0]);
                check_field("protocol", want.protocol, m_tdata[10:3]);
                check_field("src_addr", want.src_addr, m_tdata[42:11]);
                check_field("dst_addr", want.dst_addr, m_tdata[74:43]);
                check_field("header_len", want.header_len, m_tdata[80:75]);
                check_field("payload_len", want.payload_len, m_tdata[96:81]);
            end
        end
    end

    // result side: random stalls, calm stretches and one long hold on request
    initial
    begin : sink
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 40) == 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(30, 80)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input bit gappy);
        if (gappy && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        ingest_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        bit gappy;
        gappy = idle_on && $urandom_range(0, 2) != 0;
        foreach (pkt_bytes[i])
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, gappy);
    endtask

    task automatic send_noise(input int len);
        pkt_bytes.delete();
        repeat (len) pkt_bytes.push_back(8'($urandom));
        send_frame();
    endtask

    // lay out a packet: header, random options and payload, optional valid checksum
    function automatic void build_frame(pkt_desc_t d);
        int           hl;
        int           s;
        logic [159:0] h;
        hl = int'(d.ihl) * 4;
        pkt_bytes.delete();
        for (int i = 0; i < d.cap_len; i++)
            pkt_bytes.push_back(8'($urandom));
        h = {d.ver, d.ihl, 8'($urandom), d.tot_len, 16'($urandom), d.frag, 8'($urandom),
             d.proto, 16'h0000, d.src, d.dst};
        for (int i = 0; i < 20 && i < d.cap_len; i++)
            pkt_bytes[i] = h[159 - 8 * i -: 8];
        if (d.good_sum && hl >= 12 && d.cap_len >= 12)
        begin
            s = 0;
            for (int i = 0; i + 1 < hl && i + 1 < d.cap_len; i += 2)
                s += {pkt_bytes[i], pkt_bytes[i + 1]};
            while (s > 32'hFFFF)
                s = (s & 32'hFFFF) + (s >> 16);
            s = ~s & 32'hFFFF;
            pkt_bytes[10] = s[15:8];
            pkt_bytes[11] = s[7:0];
        end
    endfunction

    function automatic pkt_desc_t good_desc(input int payload);
        pkt_desc_t d;
        d.ver = VERSION_IPV4;
        d.ihl = 4'd5;
        d.tot_len = 16'(20 + payload);
        d.frag = '0;
        d.proto = 8'($urandom);
        d.src = $urandom;
        d.dst = $urandom;
        d.cap_len = 20 + payload;
        d.good_sum = 1'b1;
        return d;
    endfunction

    task automatic send_desc(input pkt_desc_t d);
        build_frame(d);
        send_frame();
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {31'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_CSUM_ENABLE)
            cfg_check = val;
        else
            cfg_v6 = val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic check, input logic v6);
        settle();
        write_reg(REG_CSUM_ENABLE, check);
        write_reg(REG_IPV6_PRESENT, v6);
    endtask

    task automatic test_runts();
        pkt_desc_t d;
        send_noise(1);
        d = good_desc(0);
        d.cap_len = 19;
        send_desc(d);
        d = good_desc(1);
        d.proto = 8'hFF;
        d.src = '0;
        d.dst = '1;
        send_desc(d);
    endtask

    task automatic test_versions();
        pkt_desc_t d;
        d = good_desc(8);
        d.ver = VERSION_IPV6;
        send_desc(d);
        d.ver = 4'h0;
        send_desc(d);
        d.ver = 4'hF;
        send_desc(d);
        set_config(1'b1, 1'b0);
        d.ver = VERSION_IPV6;
        send_desc(d);
        set_config(1'b1, 1'b1);
    endtask

    task automatic test_lengths();
        pkt_desc_t d;
        d = good_desc(0);
        send_desc(d);
        d = good_desc(10);
        d.tot_len = 16'd31;
        send_desc(d);
        d = good_desc(0);
        d.tot_len = 16'hFFFF;
        send_desc(d);
        // trailing padding beyond total length
        d = good_desc(10);
        d.tot_len = 16'd25;
        send_desc(d);
    endtask

    task automatic test_checksum();
        pkt_desc_t d;
        d = good_desc(6);
        d.good_sum = 1'b0;
        send_desc(d);
        d = good_desc(6);
        d.ihl = 4'd0;
        send_desc(d);
        d = good_desc(6);
        d.ihl = 4'd4;
        send_desc(d);
        d = good_desc(6);
        d.ihl = 4'd2;
        send_desc(d);
    endtask

    task automatic test_fragments();
        pkt_desc_t   d;
        logic [15:0] frags [6] = '{16'h2000, FLAG_DF, 16'h0001, 16'h6000, 16'hFFFF, 16'h1FFF};
        foreach (frags[i])
        begin
            d = good_desc(12);
            d.frag = frags[i];
            send_desc(d);
        end
    endtask

    task automatic test_options();
        pkt_desc_t d;
        d = good_desc(8);
        d.ihl = 4'd15;
        d.cap_len = 68;
        d.tot_len = 16'd68;
        send_desc(d);
        d.cap_len = 60;
        d.tot_len = 16'd60;
        send_desc(d);
    endtask

    task automatic test_check_off();
        pkt_desc_t d;
        set_config(1'b0, 1'b1);
        d = good_desc(0);
        send_desc(d);
        d = good_desc(10);
        d.tot_len = 16'd4;
        send_desc(d);
        // captured length falls short of the header
        d = good_desc(0);
        d.ihl = 4'd15;
        d.cap_len = 24;
        d.tot_len = 16'd24;
        send_desc(d);
        d = good_desc(10);
        d.good_sum = 1'b0;
        send_desc(d);
        d.frag = 16'h2000;
        send_desc(d);
        d = good_desc(6);
        d.ihl = 4'd0;
        send_desc(d);
        set_config(1'b1, 1'b1);
    endtask

    task automatic test_saturation();
        pkt_desc_t d;
        idle_on = 1'b0;
        d = good_desc(FRAME_CAP + 5 - 20);
        d.tot_len = 16'(FRAME_CAP);
        send_desc(d);
        settle();
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (12)
        begin
            send_noise(1);
            send_desc(good_desc($urandom_range(1, 8)));
        end
        settle();
    endtask

    task automatic random_frame();
        pkt_desc_t d;
        int        pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            send_noise($urandom_range(1, 70));
            return;
        end
        d = good_desc(0);
        if ($urandom_range(0, 3) == 0)
            d.ihl = 4'($urandom_range(6, 15));
        d.cap_len = int'(d.ihl) * 4 + $urandom_range(0, 40);
        d.tot_len = 16'(d.cap_len);
        if ($urandom_range(0, 5) == 0)
            d.tot_len = 16'(d.cap_len - $urandom_range(1, 6));
        case ($urandom_range(0, 7))
            4, 5:    d.frag = FLAG_DF;
            6:       d.frag = 16'(16'h2000 | $urandom_range(0, 7));
            7:       d.frag = 16'($urandom);
            default: d.frag = '0;
        endcase
        if (pick == 1)
            d.ver = 4'($urandom);
        if (pick == 2)
            d.ihl = 4'($urandom);
        if (pick == 3)
            d.tot_len = 16'($urandom_range(0, 120));
        if (pick == 4)
            d.good_sum = 1'b0;
        if (pick == 5)
            d.cap_len = $urandom_range(1, 30);
        send_desc(d);
    endtask

    task automatic test_random();
        int goal;
        for (int ph = 0; ph < 5; ph++)
        begin
            set_config(ph % 2 == 0, ph == 0 || ph == 3 || ph == 4);
            if (ph == 4)
                idle_on = 1'b0;
            goal = bytes_sent + RANDOM_BYTES / 5;
            while (bytes_sent < goal)
                random_frame();
        end
    endtask

    initial
    begin
        clear_shadow();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_runts();
        test_versions();
        test_lengths();
        test_checksum();
        test_fragments();
        test_options();
        test_check_off();
        test_saturation();
        test_backpressure();
        test_random();
        settle();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
